FILE: src/rotated_grid_texel_mapper_defines.svh
// ----------------------------------------------------------------------------
// Rotated grid texel mapper assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ROTATED_GRID_TEXEL_MAPPER_DEFINES_SVH
`define ROTATED_GRID_TEXEL_MAPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define RGTM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgtm assertion failed");
`define RGTM_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rgtm assertion failed");
`else
`define RGTM_ASSERT(lbl, clk, rst, prop)
`define RGTM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: src/rgtm_pkg.sv
// ----------------------------------------------------------------------------
// Rotated grid texel mapper package
// Shared types, constants and register indexes.
// ----------------------------------------------------------------------------
package rgtm_pkg;

   localparam int LOGICAL_FACTOR = 120;
   localparam int FRACTION_BITS  = 16;
   localparam int COORD_BITS     = 16;
   localparam int COORD_W        = 24;
   localparam int DIV_STEPS      = 32;
   localparam int DIV_REM_BITS   = 17;
   localparam int DVD_LOW        = FRACTION_BITS - 1;
   localparam int SAT_SHIFT      = COORD_W - FRACTION_BITS + 1;
   localparam int REM0_SHIFT     = DIV_STEPS - DVD_LOW;

   typedef enum logic [2:0] {
      CSR_GRID_CONTROL    = 3'd0,
      CSR_SCALE_DIVISOR   = 3'd1,
      CSR_NATIVE_GEOMETRY = 3'd2,
      CSR_VIEWPORT_RECT   = 3'd3,
      CSR_GUEST_RECT      = 3'd4,
      CSR_ATLAS_RECT      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [14:0] pixel_x;
      logic [14:0] pixel_y;
      logic [23:0] fallback_u;
      logic [23:0] fallback_v;
   } req_data_type;

   typedef struct packed {
      logic [31:0] texel_x;
      logic [31:0] texel_y;
      logic [23:0] coord_u;
      logic [23:0] coord_v;
      logic        grid_used;
   } rsp_data_type;

   typedef struct packed {
      logic                  en;
      logic [1:0]            rot;
      logic [15:0]           scale;
      logic [COORD_BITS-1:0] nat_w;
      logic [COORD_BITS-1:0] nat_h;
      logic [COORD_BITS-1:0] off_x;
      logic [COORD_BITS-1:0] off_y;
      logic [COORD_BITS-1:0] vp_x;
      logic [COORD_BITS-1:0] vp_y;
      logic [COORD_BITS-1:0] vp_w;
      logic [COORD_BITS-1:0] vp_h;
      logic [COORD_BITS-1:0] gs_w;
      logic [COORD_BITS-1:0] gs_h;
      logic [COORD_BITS-1:0] gs_x;
      logic [COORD_BITS-1:0] gs_y;
      logic [COORD_BITS-1:0] at_x;
      logic [COORD_BITS-1:0] at_y;
      logic [COORD_BITS-1:0] at_w;
      logic [COORD_BITS-1:0] at_h;
   } cfg_type;

   typedef struct packed {
      logic        en;
      logic [23:0] fb_u;
      logic [23:0] fb_v;
      logic [31:0] tx;
      logic [31:0] ty;
   } ctx_type;

   typedef struct packed {
      logic [1:0][DIV_REM_BITS-1:0] rem;
      logic [1:0][DIV_STEPS-1:0]    dvd;
      logic [1:0][DIV_STEPS-1:0]    quo;
      logic [1:0][DIV_REM_BITS-1:0] dsr;
      logic [1:0]                   force_ones;
      ctx_type                      ctx;
   } div_stage_type;

   typedef struct packed {
      logic [1:0][DIV_STEPS-1:0] quo;
      ctx_type                   ctx;
   } div_rsp_type;

endpackage

FILE: src/rgtm_csr.sv
// ----------------------------------------------------------------------------
// Rotated grid texel mapper register file
// Write-only configuration registers, unpacked into fields.
// ----------------------------------------------------------------------------
module rgtm_csr import rgtm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output cfg_type     cfg
);

   logic [2:0]  ctrl_ff;
   logic [15:0] scale_ff;
   logic [63:0] native_ff;
   logic [63:0] view_ff;
   logic [63:0] guest_ff;
   logic [63:0] atlas_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= '0;
         scale_ff  <= 16'd1;
         native_ff <= '0;
         view_ff   <= '0;
         guest_ff  <= '0;
         atlas_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_CONTROL:    ctrl_ff   <= csr_wdata[2:0];
            CSR_SCALE_DIVISOR:   scale_ff  <= csr_wdata[15:0];
            CSR_NATIVE_GEOMETRY: native_ff <= csr_wdata;
            CSR_VIEWPORT_RECT:   view_ff   <= csr_wdata;
            CSR_GUEST_RECT:      guest_ff  <= csr_wdata;
            CSR_ATLAS_RECT:      atlas_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.en    = ctrl_ff[0];
      cfg.rot   = ctrl_ff[2:1];
      cfg.scale = scale_ff;
      cfg.nat_w = native_ff[0*COORD_BITS +: COORD_BITS];
      cfg.nat_h = native_ff[1*COORD_BITS +: COORD_BITS];
      cfg.off_x = native_ff[2*COORD_BITS +: COORD_BITS];
      cfg.off_y = native_ff[3*COORD_BITS +: COORD_BITS];
      cfg.vp_x  = view_ff[0*COORD_BITS +: COORD_BITS];
      cfg.vp_y  = view_ff[1*COORD_BITS +: COORD_BITS];
      cfg.vp_w  = view_ff[2*COORD_BITS +: COORD_BITS];
      cfg.vp_h  = view_ff[3*COORD_BITS +: COORD_BITS];
      cfg.gs_w  = guest_ff[0*COORD_BITS +: COORD_BITS];
      cfg.gs_h  = guest_ff[1*COORD_BITS +: COORD_BITS];
      cfg.gs_x  = guest_ff[2*COORD_BITS +: COORD_BITS];
      cfg.gs_y  = guest_ff[3*COORD_BITS +: COORD_BITS];
      cfg.at_x  = atlas_ff[0*COORD_BITS +: COORD_BITS];
      cfg.at_y  = atlas_ff[1*COORD_BITS +: COORD_BITS];
      cfg.at_w  = atlas_ff[2*COORD_BITS +: COORD_BITS];
      cfg.at_h  = atlas_ff[3*COORD_BITS +: COORD_BITS];
   end

endmodule

FILE: src/rgtm_divider.sv
// ----------------------------------------------------------------------------
// Rotated grid texel mapper pipelined divider
// Two-lane restoring divider, one quotient bit per stage, context carried.
// ----------------------------------------------------------------------------
module rgtm_divider import rgtm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  div_stage_type in_data,
   output logic          out_valid,
   output div_rsp_type   out_data
);

   logic          st_valid_ff [DIV_STEPS];
   div_stage_type st_ff       [DIV_STEPS];
   div_stage_type st_in       [DIV_STEPS];

   always_comb begin
      div_stage_type               src;
      logic [DIV_REM_BITS:0]       r2;
      logic                        ge;
      for (int k = 0; k < DIV_STEPS; k++) begin
         src = (k == 0) ? in_data : st_ff[k-1];
         st_in[k] = src;
         for (int l = 0; l < 2; l++) begin
            r2 = {src.rem[l], src.dvd[l][DIV_STEPS-1]};
            ge = (r2 >= {1'b0, src.dsr[l]});
            st_in[k].rem[l] = ge ? DIV_REM_BITS'(r2 - {1'b0, src.dsr[l]})
                                 : r2[DIV_REM_BITS-1:0];
            st_in[k].dvd[l] = {src.dvd[l][DIV_STEPS-2:0], 1'b0};
            st_in[k].quo[l] = {src.quo[l][DIV_STEPS-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) st_valid_ff[k] <= 1'b0;
      end else if (advance) begin
         for (int k = 0; k < DIV_STEPS; k++)
            st_valid_ff[k] <= (k == 0) ? in_valid : st_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIV_STEPS; k++) st_ff[k] <= st_in[k];
      end
   end

   always_comb begin
      out_valid    = st_valid_ff[DIV_STEPS-1];
      out_data.ctx = st_ff[DIV_STEPS-1].ctx;
      for (int l = 0; l < 2; l++)
         out_data.quo[l] = st_ff[DIV_STEPS-1].force_ones[l] ? '1
                                                            : st_ff[DIV_STEPS-1].quo[l];
   end

endmodule

FILE: src/rotated_grid_texel_mapper.sv
// ----------------------------------------------------------------------------
// Rotated grid texel mapper
// Maps an output pixel through rotation, logical scale, viewport, guest and
// atlas rectangles to a source texel and a normalized Q8.16 coordinate.
// ----------------------------------------------------------------------------
// Request channel req_valid/req_ready/req_data carries pixel_x, pixel_y and
// the fallback coordinate; response channel rsp_valid/rsp_ready/rsp_data
// returns texel, coordinate and grid_used, one response per request.
// Configuration is written through csr_we/csr_index/csr_wdata while idle.
// Throughput: one request per cycle while the pipeline is not frozen. A
// request passes through three 32-stage dividers (logical scale, viewport
// scale, coordinate normalize) plus five arithmetic stages.
// When the receiver holds rsp_ready low with a response pending, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and loads the register defaults:
// grid disabled, scale divisor 1, all rectangles zero.
// ----------------------------------------------------------------------------
`include "rotated_grid_texel_mapper_defines.svh"
module rotated_grid_texel_mapper import rgtm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   cfg_type       cfg;
   logic          advance;

   logic          a_valid_ff;
   logic [31:0]   a_ox_ff, a_oy_ff;
   ctx_type       a_ctx_ff;
   logic [31:0]   a_ox_in, a_oy_in;

   logic          b_valid_ff;
   logic [31:0]   b_nx_ff, b_ny_ff;
   ctx_type       b_ctx_ff;

   div_stage_type d1_in;
   logic          d1_valid;
   div_rsp_type   d1_out;

   logic          c_valid_ff;
   logic [31:0]   c_px_ff, c_py_ff;
   ctx_type       c_ctx_ff;

   div_stage_type d2_in;
   logic          d2_valid;
   div_rsp_type   d2_out;

   logic          d_valid_ff;
   ctx_type       d_ctx_ff;
   ctx_type       d_ctx_in;

   div_stage_type d3_in;
   logic          d3_valid;
   div_rsp_type   d3_out;

   logic          rsp_valid_ff;
   rsp_data_type  rsp_data_ff;
   rsp_data_type  rsp_data_in;

   rgtm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // offset and rotate
   always_comb begin
      logic [31:0] x, y, rx, ry;
      x  = 32'(req_data.pixel_x) + 32'(cfg.off_x);
      y  = 32'(req_data.pixel_y) + 32'(cfg.off_y);
      rx = 32'(cfg.nat_w) - 32'd1 - x;
      ry = 32'(cfg.nat_h) - 32'd1 - y;
      case (cfg.rot)
         2'd1:    begin a_ox_in = ry; a_oy_in = x;  end
         2'd2:    begin a_ox_in = rx; a_oy_in = ry; end
         2'd3:    begin a_ox_in = y;  a_oy_in = rx; end
         default: begin a_ox_in = x;  a_oy_in = y;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= d1_valid;
         d_valid_ff <= d2_valid;
         rsp_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ox_ff       <= a_ox_in;
         a_oy_ff       <= a_oy_in;
         a_ctx_ff.en   <= cfg.en;
         a_ctx_ff.fb_u <= req_data.fallback_u;
         a_ctx_ff.fb_v <= req_data.fallback_v;
         a_ctx_ff.tx   <= '0;
         a_ctx_ff.ty   <= '0;
         b_nx_ff  <= 32'({a_ox_ff[30:0], 1'b1} * 32'(LOGICAL_FACTOR));
         b_ny_ff  <= 32'({a_oy_ff[30:0], 1'b1} * 32'(LOGICAL_FACTOR));
         b_ctx_ff <= a_ctx_ff;
         c_px_ff  <= 32'((d1_out.quo[0] - 32'(cfg.vp_x)) * 32'(cfg.gs_w));
         c_py_ff  <= 32'((d1_out.quo[1] - 32'(cfg.vp_y)) * 32'(cfg.gs_h));
         c_ctx_ff <= d1_out.ctx;
         d_ctx_ff <= d_ctx_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      d1_in.rem        = '0;
      d1_in.dvd[0]     = b_nx_ff;
      d1_in.dvd[1]     = b_ny_ff;
      d1_in.quo        = '0;
      d1_in.dsr[0]     = {cfg.scale, 1'b0};
      d1_in.dsr[1]     = {cfg.scale, 1'b0};
      d1_in.force_ones = {2{cfg.scale == 16'd0}};
      d1_in.ctx        = b_ctx_ff;
   end

   rgtm_divider u_div_logical (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (b_valid_ff),
      .in_data   (d1_in),
      .out_valid (d1_valid),
      .out_data  (d1_out)
   );

   always_comb begin
      d2_in.rem        = '0;
      d2_in.dvd[0]     = c_px_ff;
      d2_in.dvd[1]     = c_py_ff;
      d2_in.quo        = '0;
      d2_in.dsr[0]     = DIV_REM_BITS'(cfg.vp_w);
      d2_in.dsr[1]     = DIV_REM_BITS'(cfg.vp_h);
      d2_in.force_ones = {cfg.vp_h == '0, cfg.vp_w == '0};
      d2_in.ctx        = c_ctx_ff;
   end

   rgtm_divider u_div_viewport (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c_valid_ff),
      .in_data   (d2_in),
      .out_valid (d2_valid),
      .out_data  (d2_out)
   );

   always_comb begin
      d_ctx_in    = d2_out.ctx;
      d_ctx_in.tx = d2_out.quo[0] - 32'(cfg.gs_x) + 32'(cfg.at_x);
      d_ctx_in.ty = d2_out.quo[1] - 32'(cfg.gs_y) + 32'(cfg.at_y);
   end

   // coordinate = (2t+1) * 2^(F-1) / extent, saturated
   always_comb begin
      logic [32:0] odd_x, odd_y;
      logic        sat_x, sat_y;
      odd_x = {d_ctx_ff.tx, 1'b1};
      odd_y = {d_ctx_ff.ty, 1'b1};
      sat_x = odd_x >= (33'(cfg.at_w) << SAT_SHIFT);
      sat_y = odd_y >= (33'(cfg.at_h) << SAT_SHIFT);
      d3_in.rem[0]     = DIV_REM_BITS'(odd_x >> REM0_SHIFT);
      d3_in.rem[1]     = DIV_REM_BITS'(odd_y >> REM0_SHIFT);
      d3_in.dvd[0]     = {odd_x[REM0_SHIFT-1:0], {DVD_LOW{1'b0}}};
      d3_in.dvd[1]     = {odd_y[REM0_SHIFT-1:0], {DVD_LOW{1'b0}}};
      d3_in.quo        = '0;
      d3_in.dsr[0]     = DIV_REM_BITS'(cfg.at_w);
      d3_in.dsr[1]     = DIV_REM_BITS'(cfg.at_h);
      d3_in.force_ones = {(cfg.at_h == '0) || sat_y, (cfg.at_w == '0) || sat_x};
      d3_in.ctx        = d_ctx_ff;
   end

   rgtm_divider u_div_coord (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d_valid_ff),
      .in_data   (d3_in),
      .out_valid (d3_valid),
      .out_data  (d3_out)
   );

   always_comb begin
      if (d3_out.ctx.en) begin
         rsp_data_in.texel_x   = d3_out.ctx.tx;
         rsp_data_in.texel_y   = d3_out.ctx.ty;
         rsp_data_in.coord_u   = d3_out.quo[0][COORD_W-1:0];
         rsp_data_in.coord_v   = d3_out.quo[1][COORD_W-1:0];
         rsp_data_in.grid_used = 1'b1;
      end else begin
         rsp_data_in.texel_x   = '0;
         rsp_data_in.texel_y   = '0;
         rsp_data_in.coord_u   = d3_out.ctx.fb_u;
         rsp_data_in.coord_v   = d3_out.ctx.fb_v;
         rsp_data_in.grid_used = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RGTM_ASSERT(a_ready_rule, clock, reset, req_ready == (!rsp_valid || rsp_ready))
   `RGTM_ASSERT(a_pass_zero, clock, reset, (rsp_valid && !rsp_data.grid_used) |-> (rsp_data.texel_x == 32'd0 && rsp_data.texel_y == 32'd0))
   `RGTM_ASSERT(a_stall_hold, clock, reset, !advance |=> ($stable(c_valid_ff) && $stable(d_valid_ff)))
   `RGTM_ASSERT_NR(a_reset_empty, clock, reset |=> (!rsp_valid && !a_valid_ff))

endmodule
